// File: rtl/mlfq_pkg.sv
// Package for the MLFQ thread scheduler: sizes, opcodes, thread states.
// No dependencies.
`default_nettype none
package mlfq_pkg;
  localparam int THREADS_DEF = 16;
  localparam int LEVELS_DEF = 4;
  localparam logic [15:0] PERIOD_RST = 16'd100;

  localparam logic [2:0] OP_ADMIT   = 3'd0;
  localparam logic [2:0] OP_WAKE    = 3'd1;
  localparam logic [2:0] OP_PREEMPT = 3'd2;
  localparam logic [2:0] OP_YIELD   = 3'd3;
  localparam logic [2:0] OP_BLOCK   = 3'd4;
  localparam logic [2:0] OP_EXIT    = 3'd5;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] thread_id;
  } ev_t;

  typedef struct packed {
    logic       dispatch_valid;
    logic [3:0] dispatch_id;
    logic [1:0] dispatch_level;
    logic       promoted;
    logic       error;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/mlfq_front.sv
// Front end of the MLFQ scheduler: accepts items into a short queue.
// Depends on mlfq_pkg.
`default_nettype none
module mlfq_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [2:0]       in_opcode,
  input  wire  [3:0]       in_thread_id,
  output logic             ev_valid,
  output mlfq_pkg::ev_t    ev,
  input  wire              ev_take
);
  import mlfq_pkg::*;
  ev_t  q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign ev_valid = (cnt_r != 2'd0);
  assign ev = q_r[rp_r];
  assign pop = ev_valid && ev_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{opcode: in_opcode, thread_id: in_thread_id};
  end
endmodule
`default_nettype wire

// File: rtl/mlfq_back.sv
// Back end of the MLFQ scheduler: thread tables, level FIFOs in one memory,
// promotion walk and dispatch. Depends on mlfq_pkg.
`default_nettype none
module mlfq_back #(
  parameter int THREADS = mlfq_pkg::THREADS_DEF,
  parameter int LEVELS  = mlfq_pkg::LEVELS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [15:0]      cfg_data,
  input  wire              ev_valid,
  input  mlfq_pkg::ev_t    ev,
  output logic             ev_take,
  output logic             res_valid,
  output mlfq_pkg::res_t   res,
  input  wire              res_stall
);
  import mlfq_pkg::*;
  localparam int TW = $clog2(THREADS);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = $clog2(THREADS + 1);
  localparam int QA = LW + TW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_PRD   = 8'b00000100,
    S_PWR   = 8'b00001000,
    S_REQ   = 8'b00010000,
    S_DRD   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_MOD   = 8'b10000000
  } st_t;

  st_t st_r;
  logic [15:0] period_r, tick_r;
  logic [1:0]  status_r [THREADS];
  logic [LW-1:0] level_r [THREADS];
  logic [3:0]  used_r [THREADS];
  logic [TW-1:0] head_r [LEVELS];
  logic [CW-1:0] count_r [LEVELS];
  logic        run_v_r;
  logic [TW-1:0] run_id_r;
  logic [TW-1:0] mem [LEVELS*THREADS];
  logic [TW-1:0] rd_r;
  ev_t         ev_r;
  res_t        res_r;
  res_t        out_r;
  logic        out_v_r;
  logic [LW-1:0] plvl_r;
  logic [CW-1:0] pn_r, pleft_r;
  logic [TW-1:0] pbase_r;
  logic [LW-1:0] dlvl_r;
  logic [15:0] rem_r;
  logic [3:0]  mcnt_r;
  logic        byp_r;
  logic [TW-1:0] bid_r;

  logic [TW-1:0] tid;
  logic          tid_ok;
  logic [LW-1:0] q_lvl, f_lvl;
  logic          f_any;
  logic          we;
  logic [QA-1:0] waddr, raddr;
  logic [TW-1:0] wdata;
  logic [TW-1:0] slot;
  logic [LW-1:0] clvl;
  logic [15:0]   tick_nxt, rem_nxt, mstep;
  logic [16:0]   mtry;
  logic [CW:0]   psum;
  logic [TW-1:0] did;

  assign tid = TW'(ev_r.thread_id);
  assign tid_ok = ({28'd0, ev_r.thread_id} < 32'(THREADS));
  assign ev_take = (st_r == S_IDLE) && !cfg_we;
  assign res_valid = out_v_r;
  assign res = out_r;
  assign clvl = level_r[run_id_r];

  // tick remainder: rem_r tracks tick_r mod period_r
  assign tick_nxt = tick_r + 16'd1;
  assign rem_nxt = (tick_nxt == '0 || 17'(rem_r) + 17'd1 == 17'(period_r)) ? '0 :
                   rem_r + 16'd1;
  assign mtry = {rem_r, tick_r[mcnt_r]};
  assign mstep = (mtry >= 17'(period_r)) ? 16'(mtry - 17'(period_r)) : mtry[15:0];
  assign psum = (CW+1)'(pbase_r) + (CW+1)'(pn_r);
  assign did = byp_r ? bid_r : rd_r;

  always_comb begin
    f_any = 1'b0;
    f_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0) begin
        f_any = 1'b1;
        f_lvl = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    q_lvl = '0;
    slot = '0;
    case (st_r)
      S_PRD: raddr = {plvl_r, head_r[plvl_r]};
      S_PWR: begin
        we = 1'b1;
        slot = TW'(psum - (psum >= (CW+1)'(THREADS) ? (CW+1)'(THREADS) : '0));
        waddr = {{LW{1'b0}}, slot};
        wdata = rd_r;
      end
      S_REQ: begin
        we = 1'b1;
        if (ev_r.opcode == OP_ADMIT) begin
          q_lvl = '0;
          wdata = tid;
        end else if (ev_r.opcode == OP_WAKE) begin
          q_lvl = level_r[tid];
          wdata = tid;
        end else begin
          q_lvl = clvl;
          wdata = run_id_r;
          if (ev_r.opcode == OP_PREEMPT && 5'(used_r[run_id_r]) + 5'd1 >=
              (5'd1 << clvl) && 32'(clvl) < LEVELS - 1)
            q_lvl = clvl + LW'(1);
          if (ev_r.opcode == OP_BLOCK || ev_r.opcode == OP_EXIT) we = 1'b0;
        end
        slot = TW'((CW+1)'(head_r[q_lvl]) + (CW+1)'(count_r[q_lvl]) -
                   ((CW+1)'(head_r[q_lvl]) + (CW+1)'(count_r[q_lvl]) >=
                    (CW+1)'(THREADS) ? (CW+1)'(THREADS) : '0));
        waddr = {q_lvl, slot};
        raddr = {f_lvl, head_r[f_lvl]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      period_r <= PERIOD_RST;
      tick_r <= '0;
      rem_r <= '0;
      mcnt_r <= '0;
      byp_r <= 1'b0;
      run_v_r <= 1'b0;
      run_id_r <= '0;
      out_v_r <= 1'b0;
      out_r <= '0;
      for (int i = 0; i < THREADS; i++) begin
        status_r[i] <= ST_IDLE;
        level_r[i] <= '0;
        used_r[i] <= '0;
      end
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        count_r[l] <= '0;
      end
    end else begin
      if (cfg_we) period_r <= cfg_data;
      if (st_r == S_OUT && (!out_v_r || !res_stall)) begin
        out_v_r <= 1'b1;
        out_r <= res_r;
      end else if (out_v_r && !res_stall) begin
        out_v_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (cfg_we) begin
            rem_r <= '0;
            mcnt_r <= 4'hF;
            st_r <= S_MOD;
          end else if (ev_valid) begin
            ev_r <= ev;
            res_r <= '0;
            st_r <= S_CHECK;
          end
        end
        S_MOD: begin
          if (cfg_we) begin
            rem_r <= '0;
            mcnt_r <= 4'hF;
          end else begin
            rem_r <= mstep;
            mcnt_r <= mcnt_r - 4'd1;
            if (mcnt_r == 4'd0) st_r <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (ev_r.opcode > OP_EXIT ||
              (ev_r.opcode == OP_ADMIT && (!tid_ok || status_r[tid] != ST_IDLE)) ||
              (ev_r.opcode == OP_WAKE && (!tid_ok || status_r[tid] != ST_BLOCKED)) ||
              (ev_r.opcode > OP_WAKE && !run_v_r)) begin
            res_r.error <= 1'b1;
            st_r <= S_OUT;
          end else if (ev_r.opcode <= OP_WAKE) begin
            st_r <= S_REQ;
          end else begin
            tick_r <= tick_nxt;
            rem_r <= rem_nxt;
            if (ev_r.opcode == OP_PREEMPT && period_r != '0 && rem_nxt == '0) begin
              res_r.promoted <= 1'b1;
              plvl_r <= '0;
              pn_r <= '0;
              pleft_r <= count_r[0];
              pbase_r <= head_r[0];
              st_r <= S_PRD;
            end else begin
              st_r <= S_REQ;
            end
          end
        end
        S_PRD: begin
          if (pleft_r == '0) begin
            head_r[plvl_r] <= '0;
            count_r[plvl_r] <= '0;
            if (32'(plvl_r) == LEVELS - 1) begin
              head_r[0] <= pbase_r;
              count_r[0] <= pn_r;
              st_r <= S_REQ;
            end else begin
              plvl_r <= plvl_r + LW'(1);
              pleft_r <= count_r[plvl_r + LW'(1)];
            end
          end else begin
            st_r <= S_PWR;
          end
        end
        S_PWR: begin
          level_r[rd_r] <= '0;
          used_r[rd_r] <= '0;
          pn_r <= pn_r + CW'(1);
          pleft_r <= pleft_r - CW'(1);
          head_r[plvl_r] <= TW'(32'(head_r[plvl_r]) + 1 == THREADS ? 0 :
                                32'(head_r[plvl_r]) + 1);
          st_r <= S_PRD;
        end
        S_REQ: begin
          if (we) begin
            count_r[q_lvl] <= count_r[q_lvl] + CW'(1);
            status_r[wdata] <= ST_READY;
          end
          if (ev_r.opcode == OP_ADMIT) begin
            level_r[tid] <= '0;
            used_r[tid] <= '0;
          end else if (ev_r.opcode == OP_PREEMPT) begin
            level_r[run_id_r] <= q_lvl;
            used_r[run_id_r] <= (q_lvl != clvl ||
              5'(used_r[run_id_r]) + 5'd1 >= (5'd1 << clvl)) ? 4'd0 :
              used_r[run_id_r] + 4'd1;
          end else if (ev_r.opcode == OP_YIELD) begin
            used_r[run_id_r] <= '0;
          end else if (ev_r.opcode == OP_BLOCK) begin
            status_r[run_id_r] <= ST_BLOCKED;
          end else if (ev_r.opcode == OP_EXIT) begin
            status_r[run_id_r] <= ST_IDLE;
            level_r[run_id_r] <= '0;
            used_r[run_id_r] <= '0;
          end
          if (ev_r.opcode <= OP_WAKE && run_v_r) begin
            st_r <= S_OUT;
          end else if (ev_r.opcode <= OP_WAKE || f_any || we) begin
            st_r <= S_DRD;
            // pushed item lands in an empty, higher level: it is the next head
            byp_r <= !f_any || (we && q_lvl < f_lvl);
            bid_r <= wdata;
            dlvl_r <= (f_any && !(we && q_lvl < f_lvl)) ? f_lvl : q_lvl;
          end else begin
            run_v_r <= 1'b0;
            st_r <= S_OUT;
          end
        end
        S_DRD: begin
          count_r[dlvl_r] <= count_r[dlvl_r] - CW'(1);
          head_r[dlvl_r] <= TW'(32'(head_r[dlvl_r]) + 1 == THREADS ? 0 :
                                32'(head_r[dlvl_r]) + 1);
          status_r[did] <= ST_RUNNING;
          run_v_r <= 1'b1;
          run_id_r <= did;
          res_r.dispatch_valid <= 1'b1;
          res_r.dispatch_id <= 4'(did);
          res_r.dispatch_level <= 2'(level_r[did]);
          st_r <= S_OUT;
        end
        S_OUT: if (!out_v_r || !res_stall) begin
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/mlfq_thread_scheduler.sv
// Top level of the MLFQ thread scheduler: front queue plus back end.
// Depends on mlfq_pkg, mlfq_front, mlfq_back.
//
// Input channel in_valid/in_stall carries one event item (opcode, thread id).
// Output channel out_valid/out_stall returns one result item per event.
// cfg_we/cfg_data write promote_period; the user must write it only while
// idle, as the block itself does not enforce it. The back end then recomputes
// the tick remainder bit by bit in S_MOD before it takes the next item. A
// rejected item passes S_CHECK and S_OUT; one with nothing dispatched passes
// S_CHECK, S_REQ and S_OUT, one with a dispatch also S_DRD, one item at a time
// in the back end. A promotion adds a walk over the level queue memory: S_PRD
// once per level, and S_PRD then S_PWR per queued thread, as reads are registered.
// A two-entry queue in the front keeps accepting while the back end works.
// Reset (rst_n low, synchronous) makes all threads idle, empties the queues
// and sets promote_period to 100. While out_stall is high the result register
// holds, the back end finishes the next item and waits; the front queue
// fills, then in_stall rises.
`default_nettype none
module mlfq_thread_scheduler #(
  parameter int THREADS = mlfq_pkg::THREADS_DEF,
  parameter int LEVELS  = mlfq_pkg::LEVELS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [15:0] cfg_data,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [2:0]  in_opcode,
  input  wire [3:0]  in_thread_id,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_dispatch_valid,
  output logic [3:0] out_dispatch_id,
  output logic [1:0] out_dispatch_level,
  output logic       out_promoted,
  output logic       out_error
);
  import mlfq_pkg::*;
  logic ev_valid, ev_take;
  ev_t  ev;
  res_t res;

  mlfq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_thread_id,
    .ev_valid, .ev, .ev_take
  );

  mlfq_back #(.THREADS(THREADS), .LEVELS(LEVELS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_data, .ev_valid, .ev, .ev_take,
    .res_valid(out_valid), .res, .res_stall(out_stall)
  );

  assign out_dispatch_valid = res.dispatch_valid;
  assign out_dispatch_id    = res.dispatch_id;
  assign out_dispatch_level = res.dispatch_level;
  assign out_promoted       = res.promoted;
  assign out_error          = res.error;
endmodule
`default_nettype wire

// File: rtl/mlfq_checker.sv
// Port checker for the MLFQ thread scheduler, bound to the top level.
// Depends on mlfq_thread_scheduler ports only.
`default_nettype none
module mlfq_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_stall,
  input wire       out_dispatch_valid,
  input wire [3:0] out_dispatch_id,
  input wire [1:0] out_dispatch_level,
  input wire       out_promoted,
  input wire       out_error
);
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_dispatch_valid && !out_promoted)
    else $error("error result carries other fields");
  a_nodisp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dispatch_valid |-> out_dispatch_id == 4'd0 &&
    out_dispatch_level == 2'd0)
    else $error("empty dispatch not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dispatch_id))
    else $error("stalled result changed");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind mlfq_thread_scheduler mlfq_checker u_chk (.*);
`default_nettype wire
